// ===== sv/sicw_pkg.sv =====
// ----------------------------------------------------------------------------
// sicw_pkg - shared types and constants for the serial id word collector
// Word and table sizes, the tag nibble, reset values and the result record
// that the table stage hands to the output register.
// ----------------------------------------------------------------------------
package sicw_pkg;

    localparam int WORD_BITS   = 16;
    localparam int TABLE_SLOTS = 5;
    localparam int OUT_SLOTS   = 5;
    localparam int ID_BITS     = 16;
    localparam int OUT_BITS    = 16;
    localparam int DISP_BITS   = 8;
    localparam int CNT_W       = $clog2(WORD_BITS);

    localparam logic [3:0]         TAG_VALUE    = 4'hB;
    localparam logic [ID_BITS-1:0] OWN_ID_RESET = 16'hB000;

    typedef logic [WORD_BITS-1:0] t_word;

    // one result, as produced by the table stage
    typedef struct packed {
        logic [OUT_BITS-1:0]                word_value;
        logic                               tag_match;
        logic [DISP_BITS-1:0]               display_byte;
        logic                               complete_now;
        logic                               complete_flag;
        logic [OUT_SLOTS-1:0][OUT_BITS-1:0] slots;
    } t_result;

endpackage

// ===== sv/sicw_assembler.sv =====
// ----------------------------------------------------------------------------
// sicw_assembler - serial to parallel word assembly
// Shifts bits in LSB first and flags the cycle in which a word completes.
// ----------------------------------------------------------------------------
module sicw_assembler (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_bit_vld,
    input  logic            i_bit,
    output logic            o_word_done,
    output sicw_pkg::t_word o_word
);
    import sicw_pkg::*;

    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WORD_BITS - 1);

    t_word            r_shift;
    t_word            n_shift;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    // new bit enters at the top, so after a full word bit 0 is the first bit
    always_comb begin
        n_shift = {i_bit, r_shift[WORD_BITS-1:1]};
        n_cnt   = (r_cnt == LAST_BIT) ? '0 : r_cnt + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_cnt   <= '0;
        end else if (i_bit_vld) begin
            r_shift <= n_shift;
            r_cnt   <= n_cnt;
        end
    end

    assign o_word_done = i_bit_vld && (r_cnt == LAST_BIT);
    assign o_word      = n_shift;

endmodule

// ===== sv/sicw_table.sv =====
// ----------------------------------------------------------------------------
// sicw_table - seen-id table, own-id insertion and completion tracking
// Five parallel compares per completed word; table and sticky flag update
// in the same cycle, the result record goes to the output register.
// ----------------------------------------------------------------------------
module sicw_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sicw_pkg::ID_BITS-1:0]  i_cfg_wdata,
    input  logic                          i_word_done,
    input  sicw_pkg::t_word               i_word,
    output sicw_pkg::t_result             o_result
);
    import sicw_pkg::*;

    t_word                    r_table [TABLE_SLOTS];
    t_word                    n_table [TABLE_SLOTS];
    t_word                    sent    [TABLE_SLOTS];
    logic                     r_done;
    logic                     n_done;
    logic [ID_BITS-1:0]       r_own_id;
    t_word                    own_word;
    logic                     tag;
    logic                     found;
    logic                     found_id;
    logic                     now;
    logic [TABLE_SLOTS-1:0]   empty_a;
    logic [TABLE_SLOTS-1:0]   empty_b;
    logic [TABLE_SLOTS-1:0]   sel_a;
    logic [TABLE_SLOTS-1:0]   sel_b;

    assign own_word = t_word'(r_own_id);
    assign tag      = (i_word[WORD_BITS-1 -: 4] == TAG_VALUE);

    // first pass: store a new tagged word in the highest empty slot
    always_comb begin
        found = 1'b0;
        sel_a = '0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            empty_a[i] = (r_table[i] == '0);
            if (r_table[i] == i_word) begin
                found = 1'b1;
            end
        end
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (empty_a[i]) begin
                sel_a    = '0;
                sel_a[i] = 1'b1;
            end
        end
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            n_table[i] = (tag && !found && sel_a[i]) ? i_word : r_table[i];
        end
    end

    // second pass: outgoing copy with own id in the highest empty slot
    always_comb begin
        found_id = 1'b0;
        sel_b    = '0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            empty_b[i] = (n_table[i] == '0);
            if (n_table[i] == own_word) begin
                found_id = 1'b1;
            end
        end
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (empty_b[i]) begin
                sel_b    = '0;
                sel_b[i] = 1'b1;
            end
        end
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            sent[i] = (!found_id && sel_b[i]) ? own_word : n_table[i];
        end
        now    = (empty_b == '0) && !r_done;
        n_done = r_done || (empty_b == '0);
    end

    // result record
    always_comb begin
        o_result.word_value    = OUT_BITS'(i_word);
        o_result.tag_match     = tag;
        o_result.display_byte  = tag ? i_word[DISP_BITS-1:0] : '0;
        o_result.complete_now  = now;
        o_result.complete_flag = n_done;
        for (int i = 0; i < OUT_SLOTS; i++) begin
            if (i < TABLE_SLOTS) begin
                o_result.slots[i] = OUT_BITS'(sent[i]);
            end else begin
                o_result.slots[i] = '0;
            end
        end
    end

    // table, sticky flag and own id register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                r_table[i] <= '0;
            end
            r_done   <= 1'b0;
            r_own_id <= OWN_ID_RESET;
        end else begin
            if (i_word_done) begin
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    r_table[i] <= n_table[i];
                end
                r_done <= n_done;
            end
            if (i_cfg_we) begin
                r_own_id <= i_cfg_wdata;
            end
        end
    end

endmodule

// ===== sv/serial_id_word_collector.sv =====
// ----------------------------------------------------------------------------
// serial_id_word_collector - top level
// Collects serial id words into a five-slot table and reports each word.
//
//   channel   direction  handshake             payload
//   bit in    in         start / busy          i_bit_value
//   config    in         i_cfg_we              i_cfg_wdata (own id)
//   result    out        o_strobe (1 cycle)    o_word_value .. o_out_slot_4
//
// One bit is taken per clock while start is high and busy is low; busy is
// high only while reset is held and until the run register is set after it
// is released. After a word's last bit is transferred it passes the input
// register, then the table compares into the result register, which
// registers the strobe and the result together.
// Reset (synchronous, active low) empties the table, clears the bit count
// and the complete flag and restores the own id.
// The receiver cannot stall; each result is strobed for one cycle only and held until the next word completes.
// ----------------------------------------------------------------------------
module serial_id_word_collector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_bit_value,
    input  logic                            i_cfg_we,
    input  logic [sicw_pkg::ID_BITS-1:0]    i_cfg_wdata,
    output logic                            o_strobe,
    output logic [sicw_pkg::OUT_BITS-1:0]   o_word_value,
    output logic                            o_tag_match,
    output logic [sicw_pkg::DISP_BITS-1:0]  o_display_byte,
    output logic                            o_complete_now,
    output logic                            o_complete_flag,
    output logic [sicw_pkg::OUT_BITS-1:0]   o_out_slot_0,
    output logic [sicw_pkg::OUT_BITS-1:0]   o_out_slot_1,
    output logic [sicw_pkg::OUT_BITS-1:0]   o_out_slot_2,
    output logic [sicw_pkg::OUT_BITS-1:0]   o_out_slot_3,
    output logic [sicw_pkg::OUT_BITS-1:0]   o_out_slot_4
);
    import sicw_pkg::*;

    logic    r_run;
    logic    r_in_vld;
    logic    r_in_bit;
    logic    word_done;
    t_word   word;
    t_result result;
    t_result r_out;
    logic    r_strobe;

    // ready from the cycle after reset releases
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    assign busy = !r_run;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_bit <= i_bit_value;
    end

    sicw_assembler u_asm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bit_vld   (r_in_vld),
        .i_bit       (r_in_bit),
        .o_word_done (word_done),
        .o_word      (word)
    );

    sicw_table u_tbl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_word_done (word_done),
        .i_word      (word),
        .o_result    (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= word_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (word_done) begin
            r_out <= result;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_word_value    = r_out.word_value;
    assign o_tag_match     = r_out.tag_match;
    assign o_display_byte  = r_out.display_byte;
    assign o_complete_now  = r_out.complete_now;
    assign o_complete_flag = r_out.complete_flag;
    assign o_out_slot_0    = r_out.slots[0];
    assign o_out_slot_1    = r_out.slots[1];
    assign o_out_slot_2    = r_out.slots[2];
    assign o_out_slot_3    = r_out.slots[3];
    assign o_out_slot_4    = r_out.slots[4];

endmodule

// ===== sv/sicw_checker.sv =====
// ----------------------------------------------------------------------------
// sicw_checker - port-level checks for the serial id word collector
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module sicw_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_strobe,
    input  logic [sicw_pkg::OUT_BITS-1:0]   o_word_value,
    input  logic                            o_tag_match,
    input  logic [sicw_pkg::DISP_BITS-1:0]  o_display_byte,
    input  logic                            o_complete_now,
    input  logic                            o_complete_flag
);
    import sicw_pkg::*;

    // a word needs many bit transfers, so results never come back to back
    a_no_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two results in adjacent cycles");

    // reset drops any pending result
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

    // the first-time event always comes with the sticky flag
    a_now_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_complete_now) |-> o_complete_flag)
        else $error("complete event without complete flag");

    // tag flag follows the word's top nibble
    a_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_tag_match == (o_word_value[OUT_BITS-1 -: 4] == TAG_VALUE)))
        else $error("tag flag disagrees with word");

    // untagged words show a blank display byte
    a_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_tag_match) |-> (o_display_byte == '0))
        else $error("display byte set for untagged word");

endmodule

bind serial_id_word_collector sicw_checker u_sicw_checker (.*);
